/* hw/rtl/swd_debug_port_target_macros.svh */
// Assertion macros shared by the debug port target.
`ifndef SWD_DEBUG_PORT_TARGET_MACROS_SVH
`define SWD_DEBUG_PORT_TARGET_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SWDP_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SWDP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* hw/rtl/swdp_pkg.sv */
`default_nettype none
package swdp_pkg;

  localparam logic [7:0] HdrOnes     = 8'hFF;
  localparam logic [7:0] HdrJtagA    = 8'h79;
  localparam logic [7:0] HdrJtagB    = 8'hE7;
  localparam logic [5:0] OnesCap     = 6'd56;
  localparam logic [5:0] LineResetBits = 6'd50;
  localparam logic [31:0] AbortMask  = 32'h0000_00B2;
  localparam logic [31:0] StatForced = 32'hA800_0000;
  localparam logic [31:0] WdataErrBit = 32'h0000_0080;
  localparam logic [3:0]  BankIdr    = 4'hF;

  localparam logic [2:0] AckNone  = 3'd0;
  localparam logic [2:0] AckOk    = 3'd1;
  localparam logic [2:0] AckWait  = 3'd2;
  localparam logic [2:0] AckFault = 3'd4;

  localparam logic [1:0] BusNone  = 2'd0;
  localparam logic [1:0] BusRead  = 2'd1;
  localparam logic [1:0] BusWrite = 2'd2;

  localparam logic [1:0] AddrA0 = 2'd0;
  localparam logic [1:0] AddrA4 = 2'd1;
  localparam logic [1:0] AddrA8 = 2'd2;
  localparam logic [1:0] AddrAC = 2'd3;

  localparam int unsigned QueueDepthDefault = 2;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic        is_resp;
    logic        is_ones;
    logic        is_jtag;
    logic        bad_hdr;
    logic        apndp;
    logic        rnw;
    logic [1:0]  addr;
    logic        wpar_err;
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic        rpar;
  } req_t;

  typedef struct packed {
    logic        reply_valid;
    logic [2:0]  ack;
    logic [31:0] read_data;
    logic        read_parity;
    logic [1:0]  bus_request;
    logic [31:0] bus_address;
    logic [1:0]  bus_size;
    logic [31:0] bus_write_data;
    logic        write_data_error;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/swdp_front.sv */
`default_nettype none
// Front part: decodes a request, marks JTAG select bytes and checks parity.
module swdp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          action_i,
  input  wire logic [7:0]    header_i,
  input  wire logic [31:0]   write_data_i,
  input  wire logic          write_parity_i,
  input  wire logic [31:0]   bus_read_data_i,
  output logic               q_valid_o,
  input  wire logic          q_stall_i,
  output swdp_pkg::req_t     q_req_o
);
  import swdp_pkg::*;

  logic   v_q;
  req_t   r_q, r_d;
  logic   keep;

  // Classify the request; JTAG select bytes need no back work but still clear
  // the ones count, so they travel as a plain marker.
  always_comb begin
    r_d = '0;
    r_d.is_resp  = action_i;
    r_d.is_ones  = !action_i && (header_i == HdrOnes);
    r_d.apndp    = header_i[1];
    r_d.rnw      = header_i[2];
    r_d.addr     = header_i[4:3];
    r_d.bad_hdr  = !header_i[0] || !header_i[7] ||
                   (header_i[5] != (header_i[1] ^ header_i[2] ^ header_i[3] ^ header_i[4]));
    r_d.wpar_err = (^write_data_i) != write_parity_i;
    r_d.wdata    = write_data_i;
    r_d.rdata    = bus_read_data_i;
    r_d.rpar     = ^bus_read_data_i;
    keep = 1'b1;
    if (!action_i && (header_i == HdrJtagA || header_i == HdrJtagB)) begin
      // Marker: treated in back as a bare ones-count clear.
      r_d.is_jtag = 1'b1;
      r_d.is_ones = 1'b0;
      r_d.bad_hdr = 1'b0;
      r_d.is_resp = 1'b0;
    end
  end

  assign in_stall  = v_q && q_stall_i;
  assign q_valid_o = v_q;
  assign q_req_o   = r_q;

  // Register stage between the host side and the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!in_stall) begin
      v_q <= in_valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall && in_valid) begin
      r_q <= r_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/swdp_queue.sv */
`default_nettype none
// Short queue between the front and the back.
module swdp_queue #(
  parameter int unsigned Depth = swdp_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        w_valid_i,
  output logic             w_stall_o,
  input  wire swdp_pkg::req_t w_req_i,
  output logic             r_valid_o,
  input  wire logic        r_stall_i,
  output swdp_pkg::req_t   r_req_o
);
  import swdp_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  req_t              mem_q [Depth];
  logic [Aw-1:0]     wp_q, rp_q;
  logic [Aw:0]       cnt_q;
  logic              push, pop;

  assign w_stall_o = (cnt_q == (Aw+1)'(Depth));
  assign r_valid_o = (cnt_q != '0);
  assign r_req_o   = mem_q[rp_q];
  assign push = w_valid_i && !w_stall_o;
  assign pop  = r_valid_o && !r_stall_i;

  // Pointers wrap at the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= w_req_i;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/swdp_back.sv */
`default_nettype none
// Back part: owns the DP and AP registers and builds the result.
module swdp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    dp_id_i,
  input  wire logic [31:0]    ap_id_i,
  input  wire logic           q_valid_i,
  output logic                q_stall_o,
  input  wire swdp_pkg::req_t q_req_i,
  output logic                out_valid,
  input  wire logic           out_stall,
  output swdp_pkg::res_t      res_o,
  output logic                pending_o
);
  import swdp_pkg::*;

  logic [31:0] ctrl_q, ctrl_d, rbuf_q, rbuf_d, csw_q, csw_d, tar_q, tar_d;
  logic [3:0]  sel_q, sel_d;
  logic [5:0]  ones_q, ones_d;
  logic        pend_q, pend_d;
  logic        ov_q;
  res_t        res_q, res_d;
  logic        emit, take;
  logic [1:0]  sz;
  logic [31:0] v;
  logic [6:0]  ones_sum;
  req_t        r;

  assign r         = q_req_i;
  assign q_stall_o = ov_q && out_stall;
  assign take      = q_valid_i && !q_stall_o;
  assign out_valid = ov_q;
  assign res_o     = res_q;
  assign pending_o = pend_q;
  assign sz        = (csw_q[2:0] > 3'd2) ? 2'd2 : csw_q[1:0];
  assign ones_sum  = {1'b0, ones_q} + 7'd8;

  // Execute one request against the register set.
  always_comb begin
    ctrl_d = ctrl_q; rbuf_d = rbuf_q; csw_d = csw_q; tar_d = tar_q;
    sel_d = sel_q; ones_d = ones_q; pend_d = pend_q;
    res_d = '0; emit = 1'b0; v = '0;
    if (r.is_ones) begin
      ones_d = (ones_sum > {1'b0, OnesCap}) ? OnesCap : ones_sum[5:0];
      if (ones_d >= LineResetBits) begin
        ctrl_d = '0; sel_d = '0; csw_d = '0; tar_d = '0; pend_d = 1'b0;
      end
    end else if (r.is_jtag) begin
      // A JTAG select byte only clears the ones count.
      ones_d = '0;
    end else if (r.is_resp) begin
      // A bus response completes a pending DRW read.
      if (pend_q) begin
        pend_d = 1'b0;
        rbuf_d = r.rdata;
        emit = 1'b1;
        res_d.reply_valid = 1'b1;
        res_d.ack = AckOk;
        res_d.read_data = r.rdata;
        res_d.read_parity = r.rpar;
      end
    end else begin
      ones_d = '0;
      emit = 1'b1;
      res_d.reply_valid = 1'b1;
      if (r.bad_hdr) begin
        res_d.ack = AckFault;
      end else if (pend_q) begin
        res_d.ack = AckWait;
      end else if (r.rnw) begin
        res_d.ack = AckOk;
        if (r.apndp) begin
          if (sel_q == BankIdr) v = (r.addr == AddrAC) ? ap_id_i : '0;
          else if (r.addr == AddrA0) v = csw_q;
          else if (r.addr == AddrA4) v = tar_q;
          else if (r.addr == AddrAC) begin
            res_d.reply_valid = 1'b0;
            res_d.ack = AckNone;
            res_d.bus_request = BusRead;
            res_d.bus_address = tar_q;
            res_d.bus_size = sz;
            if (csw_q[5:4] == 2'd1 || csw_q[5:4] == 2'd2) tar_d = tar_q + (32'd1 << sz);
            pend_d = 1'b1;
          end
          if (!(sel_q != BankIdr && r.addr == AddrAC)) rbuf_d = v;
        end else begin
          case (r.addr)
            AddrA0: v = dp_id_i;
            AddrA4: v = ctrl_q | StatForced;
            AddrAC: v = rbuf_q;
            default: v = '0;
          endcase
        end
        if (res_d.reply_valid) begin
          res_d.read_data = v;
          res_d.read_parity = ^v;
        end
      end else begin
        res_d.ack = AckOk;
        if (r.wpar_err) begin
          ctrl_d = ctrl_q | WdataErrBit;
          res_d.write_data_error = 1'b1;
        end else if (r.apndp) begin
          if (sel_q == 4'd0) begin
            case (r.addr)
              AddrA0: csw_d = r.wdata;
              AddrA4: tar_d = r.wdata;
              AddrAC: begin
                res_d.bus_request = BusWrite;
                res_d.bus_address = tar_q;
                res_d.bus_size = sz;
                res_d.bus_write_data = r.wdata;
                if (csw_q[5:4] == 2'd1 || csw_q[5:4] == 2'd2) tar_d = tar_q + (32'd1 << sz);
              end
              default: ;
            endcase
          end
        end else begin
          case (r.addr)
            AddrA0: if (r.wdata[0]) ctrl_d = ctrl_q & ~AbortMask;
            AddrA4: ctrl_d = r.wdata;
            AddrA8: sel_d = r.wdata[7:4];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0; rbuf_q <= '0; csw_q <= '0; tar_q <= '0;
      sel_q <= '0; ones_q <= '0; pend_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (take) begin
        ctrl_q <= ctrl_d; rbuf_q <= rbuf_d; csw_q <= csw_d; tar_q <= tar_d;
        sel_q <= sel_d; ones_q <= ones_d; pend_q <= pend_d;
      end
      if (!q_stall_o) ov_q <= take && emit;
    end
  end

  // Result register toward the host side.
  always_ff @(posedge clk_i) begin
    if (!q_stall_o) res_q <= res_d;
  end
endmodule
`default_nettype wire

/* hw/rtl/swd_debug_port_target.sv */
// Channel   | handshake            | payload
// input     | in_valid / in_stall  | action_i header_i write_data_i write_parity_i bus_read_data_i
// result    | out_valid / out_stall| reply_valid_o ack_o read_data_o read_parity_o bus_*_o
//                                    write_data_error_o
// config    | cfg_we_i             | cfg_index_i cfg_data_i
// One request per cycle is accepted when nothing stalls; a result passes through the
// decode register, the queue and the result register on its way out.
// The rate is set by the single register-update step in the back part.
// Reset is asynchronous and active low; it restores the ID values and clears the control state.
// A stall on the result side fills the queue (two entries by default) before the input stalls.
`default_nettype none
module swd_debug_port_target #(
  parameter int unsigned QueueDepth = swdp_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action_i,
  input  wire logic [7:0]  header_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic        write_parity_i,
  input  wire logic [31:0] bus_read_data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             reply_valid_o,
  output logic [2:0]       ack_o,
  output logic [31:0]      read_data_o,
  output logic             read_parity_o,
  output logic [1:0]       bus_request_o,
  output logic [31:0]      bus_address_o,
  output logic [1:0]       bus_size_o,
  output logic [31:0]      bus_write_data_o,
  output logic             write_data_error_o
);
  import swdp_pkg::*;
  `include "swd_debug_port_target_macros.svh"

  logic [31:0] dp_id_q, ap_id_q;
  logic        fq_valid, fq_stall, qb_valid, qb_stall, pend;
  req_t        fq_req, qb_req;
  res_t        res;

  // Identification registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_id_q <= 32'h0BB1_1477;
      ap_id_q <= 32'h0477_0021;
    end else if (cfg_we_i) begin
      if (!cfg_index_i) dp_id_q <= cfg_data_i;
      else ap_id_q <= cfg_data_i;
    end
  end

  swdp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .action_i, .header_i, .write_data_i,
    .write_parity_i, .bus_read_data_i,
    .q_valid_o(fq_valid), .q_stall_i(fq_stall), .q_req_o(fq_req)
  );

  swdp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .w_valid_i(fq_valid), .w_stall_o(fq_stall), .w_req_i(fq_req),
    .r_valid_o(qb_valid), .r_stall_i(qb_stall), .r_req_o(qb_req)
  );

  swdp_back u_back (
    .clk_i, .rst_ni, .dp_id_i(dp_id_q), .ap_id_i(ap_id_q),
    .q_valid_i(qb_valid), .q_stall_o(qb_stall), .q_req_i(qb_req),
    .out_valid, .out_stall, .res_o(res), .pending_o(pend)
  );

  assign reply_valid_o      = res.reply_valid;
  assign ack_o              = res.ack;
  assign read_data_o        = res.read_data;
  assign read_parity_o      = res.read_parity;
  assign bus_request_o      = res.bus_request;
  assign bus_address_o      = res.bus_address;
  assign bus_size_o         = res.bus_size;
  assign bus_write_data_o   = res.bus_write_data;
  assign write_data_error_o = res.write_data_error;

  `SWDP_ASSERT_IMP(a_read_parity, clk_i, rst_ni, out_valid, read_parity_o == ^read_data_o)
  `SWDP_ASSERT_IMP(a_bus_read_silent, clk_i, rst_ni,
    out_valid && bus_request_o == BusRead, !reply_valid_o && ack_o == AckNone)
  `SWDP_ASSERT_IMP(a_read_sets_pending, clk_i, rst_ni,
    out_valid && !out_stall && bus_request_o == BusRead, pend)
  `SWDP_ASSERT_NEXT(a_result_held, clk_i, rst_ni,
    out_valid && out_stall, out_valid && $stable(res))
endmodule
`default_nettype wire
